### src/q2e_pkg.sv
package q2e_pkg;

  // Width of the product sums (Q.28 values times two)
  localparam int unsigned PW = 34;
  // Width of the clamped pitch argument, +-2^28
  localparam int unsigned TW = 30;
  // Square root datapath width and number of digit cells
  localparam int unsigned SQ_W = 58;
  localparam int unsigned SQ_STEPS = 29;
  localparam int unsigned SQ_RW = 29;
  // CORDIC vector and angle widths
  localparam int unsigned CW = 37;
  localparam int unsigned ZW = 34;

  localparam logic signed [PW-1:0] ONE_Q28 = PW'(64'sd1 << 28);
  localparam logic signed [TW-1:0] T_ONE = TW'(64'sd1 << 28);
  localparam logic signed [TW-1:0] T_MONE = -T_ONE;
  localparam logic [SQ_W-1:0] ONE_Q56 = SQ_W'(64'd1 << 56);
  localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(64'sd1 << 30);

  // Square root cell word: remaining radicand and partial root
  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] res;
  } sq_t;

  // CORDIC cell word
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cord_t;

  // atan(2^-i), 2^31 = pi, truncated
  function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
    logic signed [ZW-1:0] a;
    case (i)
      0: a = 34'sd536870912;
      1: a = 34'sd316933406;
      2: a = 34'sd167458907;
      3: a = 34'sd85004756;
      4: a = 34'sd42667331;
      5: a = 34'sd21354465;
      6: a = 34'sd10679838;
      7: a = 34'sd5340245;
      8: a = 34'sd2670163;
      9: a = 34'sd1335087;
      10: a = 34'sd667544;
      11: a = 34'sd333772;
      12: a = 34'sd166886;
      13: a = 34'sd83443;
      14: a = 34'sd41721;
      15: a = 34'sd20860;
      16: a = 34'sd10430;
      17: a = 34'sd5215;
      18: a = 34'sd2607;
      19: a = 34'sd1303;
      20: a = 34'sd651;
      21: a = 34'sd325;
      22: a = 34'sd162;
      23: a = 34'sd81;
      24: a = 34'sd40;
      25: a = 34'sd20;
      26: a = 34'sd10;
      27: a = 34'sd5;
      28: a = 34'sd2;
      29: a = 34'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### src/q2e_sqrt_cell.sv
module q2e_sqrt_cell #(
  parameter int unsigned BIT_POS = 56
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  q2e_pkg::sq_t    sq_i,
  output q2e_pkg::sq_t    sq_o
);

  localparam logic [q2e_pkg::SQ_W-1:0] BIT = q2e_pkg::SQ_W'(64'd1 << BIT_POS);

  logic [q2e_pkg::SQ_W-1:0] trial;
  q2e_pkg::sq_t             sq_d;
  q2e_pkg::sq_t             sq_q;

  // Try one root digit: subtract when it fits
  always_comb begin
    trial = sq_i.res + BIT;
    if (sq_i.v >= trial) begin
      sq_d.v   = sq_i.v - trial;
      sq_d.res = (sq_i.res >> 1) + BIT;
    end else begin
      sq_d.v   = sq_i.v;
      sq_d.res = sq_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

### src/q2e_cordic_cell.sv
module q2e_cordic_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  q2e_pkg::cord_t  c_i,
  output q2e_pkg::cord_t  c_o
);

  localparam logic signed [q2e_pkg::ZW-1:0] ANG = q2e_pkg::atan_entry(SHIFT);

  logic signed [q2e_pkg::CW-1:0] dx;
  logic signed [q2e_pkg::CW-1:0] dy;
  q2e_pkg::cord_t                c_d;
  q2e_pkg::cord_t                c_q;

  // Rotate toward the x axis by one micro-angle
  always_comb begin
    dx = c_i.y >>> SHIFT;
    dy = c_i.x >>> SHIFT;
    c_d.zero = c_i.zero;
    if (c_i.y < 0) begin
      c_d.x = c_i.x - dx;
      c_d.y = c_i.y + dy;
      c_d.z = c_i.z - ANG;
    end else begin
      c_d.x = c_i.x + dx;
      c_d.y = c_i.y - dy;
      c_d.z = c_i.z + ANG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;

endmodule

### src/quaternion_to_euler_top.sv
// Quaternion to ZYX Euler angles (roll, pitch, yaw).
// Input channel: in_valid_i/in_ready_o with quat_w_i..quat_z_i, signed Q2.14.
// Output channel: out_valid_o/out_ready_i with roll_angle_o, pitch_angle_o,
// yaw_angle_o, signed binary angles where 2^(ANGLE_WIDTH-1) stands for pi.
// Throughput: one word per cycle while the receiver takes words.
// Pipeline from accept to out_valid_o: three product/sum stages, 29
// square root digit cells for the pitch cosine, one quadrant stage,
// CORDIC_STAGES rotation cells and one rounding register.
// The whole pipeline advances as one: when the output register holds a word
// that is not taken, every stage holds and in_ready_o drops in that cycle;
// otherwise a new word enters every cycle.
// Reset clears all valid flags; data registers are not reset. No state
// carries from one word to the next.
// Atan2 of a zero vector gives a zero angle; the pitch argument is clamped
// to plus or minus one before the arcsine.
module quaternion_to_euler_top #(
  parameter int unsigned ANGLE_WIDTH   = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [15:0]            quat_w_i,
  input  logic signed [15:0]            quat_x_i,
  input  logic signed [15:0]            quat_y_i,
  input  logic signed [15:0]            quat_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [ANGLE_WIDTH-1:0] roll_angle_o,
  output logic signed [ANGLE_WIDTH-1:0] pitch_angle_o,
  output logic signed [ANGLE_WIDTH-1:0] yaw_angle_o
);

  localparam int unsigned PW = q2e_pkg::PW;
  localparam int unsigned TW = q2e_pkg::TW;
  localparam int unsigned CW = q2e_pkg::CW;
  localparam int unsigned ZW = q2e_pkg::ZW;
  localparam int unsigned SQS = q2e_pkg::SQ_STEPS;
  localparam int unsigned SH = 32 - ANGLE_WIDTH;
  localparam int unsigned L = 3 + SQS + 1 + CORDIC_STAGES + 1;

  logic         en;
  logic [L-1:0] vld_q;

  assign en          = !vld_q[L-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[L-1];

  // Shift the valid flags with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], in_valid_i};
    end
  end

  // Stage 1: component products
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      wy_q <= quat_w_i * quat_y_i;
      zx_q <= quat_z_i * quat_x_i;
      wz_q <= quat_w_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
    end
  end

  // Stage 2: numerators, denominators and clamped pitch argument
  logic signed [PW-1:0] rn_d, rd_d, yn_d, yd_d, pt_d;
  logic signed [TW-1:0] tc_d;
  logic signed [PW-1:0] rn_q, rd_q, yn_q, yd_q;
  logic signed [TW-1:0] tc_q;

  always_comb begin
    rn_d = (PW'(wx_q) + PW'(yz_q)) <<< 1;
    rd_d = q2e_pkg::ONE_Q28 - ((PW'(xx_q) + PW'(yy_q)) <<< 1);
    yn_d = (PW'(wz_q) + PW'(xy_q)) <<< 1;
    yd_d = q2e_pkg::ONE_Q28 - ((PW'(yy_q) + PW'(zz_q)) <<< 1);
    pt_d = (PW'(wy_q) - PW'(zx_q)) <<< 1;
    if (pt_d > PW'(q2e_pkg::T_ONE)) begin
      tc_d = q2e_pkg::T_ONE;
    end else if (pt_d < PW'(q2e_pkg::T_MONE)) begin
      tc_d = q2e_pkg::T_MONE;
    end else begin
      tc_d = pt_d[TW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rn_q <= rn_d;
      rd_q <= rd_d;
      yn_q <= yn_d;
      yd_q <= yd_d;
      tc_q <= tc_d;
    end
  end

  // Stage 3: square of the pitch argument
  logic signed [2*TW-1:0] tsq_q;
  logic signed [PW-1:0]   rn3_q, rd3_q, yn3_q, yd3_q;
  logic signed [TW-1:0]   tc3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tsq_q <= tc_q * tc_q;
      rn3_q <= rn_q;
      rd3_q <= rd_q;
      yn3_q <= yn_q;
      yd3_q <= yd_q;
      tc3_q <= tc_q;
    end
  end

  // Square root chain for the pitch cosine, with roll and yaw alongside
  q2e_pkg::sq_t         sq_c [SQS+1];
  logic signed [PW-1:0] rn_dl_q [SQS];
  logic signed [PW-1:0] rd_dl_q [SQS];
  logic signed [PW-1:0] yn_dl_q [SQS];
  logic signed [PW-1:0] yd_dl_q [SQS];
  logic signed [TW-1:0] tc_dl_q [SQS];

  assign sq_c[0].v   = q2e_pkg::ONE_Q56 - tsq_q[q2e_pkg::SQ_W-1:0];
  assign sq_c[0].res = '0;

  for (genvar i = 0; i < SQS; i++) begin : g_sqrt
    q2e_sqrt_cell #(
      .BIT_POS(2 * (SQS - 1 - i))
    ) u_cell (
      .clk_i(clk_i),
      .en_i (en),
      .sq_i (sq_c[i]),
      .sq_o (sq_c[i+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rn_dl_q[0] <= rn3_q;
      rd_dl_q[0] <= rd3_q;
      yn_dl_q[0] <= yn3_q;
      yd_dl_q[0] <= yd3_q;
      tc_dl_q[0] <= tc3_q;
      for (int k = 1; k < SQS; k++) begin
        rn_dl_q[k] <= rn_dl_q[k-1];
        rd_dl_q[k] <= rd_dl_q[k-1];
        yn_dl_q[k] <= yn_dl_q[k-1];
        yd_dl_q[k] <= yd_dl_q[k-1];
        tc_dl_q[k] <= tc_dl_q[k-1];
      end
    end
  end

  // Quadrant stage: fold left half plane vectors by a quarter turn
  function automatic q2e_pkg::cord_t fold(input logic signed [CW-1:0] y,
                                          input logic signed [CW-1:0] x);
    q2e_pkg::cord_t c;
    c.zero = (x == '0) && (y == '0);
    c.x = x;
    c.y = y;
    c.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        c.x = y;
        c.y = -x;
        c.z = q2e_pkg::HALF_PI_Z;
      end else begin
        c.x = -y;
        c.y = x;
        c.z = -q2e_pkg::HALF_PI_Z;
      end
    end
    return c;
  endfunction

  q2e_pkg::cord_t roll_c  [CORDIC_STAGES+1];
  q2e_pkg::cord_t pitch_c [CORDIC_STAGES+1];
  q2e_pkg::cord_t yaw_c   [CORDIC_STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_c[0]  <= fold(CW'(rn_dl_q[SQS-1]), CW'(rd_dl_q[SQS-1]));
      pitch_c[0] <= fold(CW'(tc_dl_q[SQS-1]), CW'({1'b0, sq_c[SQS].res[q2e_pkg::SQ_RW-1:0]}));
      yaw_c[0]   <= fold(CW'(yn_dl_q[SQS-1]), CW'(yd_dl_q[SQS-1]));
    end
  end

  // Rotation cells, three lanes
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    q2e_cordic_cell #(.SHIFT(i)) u_roll (
      .clk_i(clk_i), .en_i(en), .c_i(roll_c[i]), .c_o(roll_c[i+1])
    );
    q2e_cordic_cell #(.SHIFT(i)) u_pitch (
      .clk_i(clk_i), .en_i(en), .c_i(pitch_c[i]), .c_o(pitch_c[i+1])
    );
    q2e_cordic_cell #(.SHIFT(i)) u_yaw (
      .clk_i(clk_i), .en_i(en), .c_i(yaw_c[i]), .c_o(yaw_c[i+1])
    );
  end

  // Round half up to the output angle width
  logic signed [ZW-1:0] roll_r, pitch_r, yaw_r;

  if (SH > 0) begin : g_round
    localparam logic signed [ZW-1:0] HALF = ZW'(64'sd1 << (SH - 1));
    assign roll_r  = roll_c[CORDIC_STAGES].z + HALF;
    assign pitch_r = pitch_c[CORDIC_STAGES].z + HALF;
    assign yaw_r   = yaw_c[CORDIC_STAGES].z + HALF;
  end else begin : g_noround
    assign roll_r  = roll_c[CORDIC_STAGES].z;
    assign pitch_r = pitch_c[CORDIC_STAGES].z;
    assign yaw_r   = yaw_c[CORDIC_STAGES].z;
  end

  logic signed [ANGLE_WIDTH-1:0] roll_q, pitch_q, yaw_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= roll_c[CORDIC_STAGES].zero  ? '0 : roll_r[SH +: ANGLE_WIDTH];
      pitch_q <= pitch_c[CORDIC_STAGES].zero ? '0 : pitch_r[SH +: ANGLE_WIDTH];
      yaw_q   <= yaw_c[CORDIC_STAGES].zero   ? '0 : yaw_r[SH +: ANGLE_WIDTH];
    end
  end

  assign roll_angle_o  = roll_q;
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o   = yaw_q;

  // An accepted word enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted word did not enter the pipeline");

  // A stalled pipeline keeps every word in place
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  // The pitch cosine never exceeds one
  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3+SQS-1] |-> (sq_c[SQS].res <= q2e_pkg::SQ_W'(64'd1 << 28)))
    else $error("square root above one");

  // A stalled output is not replaced by the next word
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

endmodule

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AW = 16;
  localparam int unsigned STAGES = 16;
  localparam int unsigned LATENCY = 34 + STAGES;
  localparam int unsigned RAND_WORDS = 1700;

  typedef struct packed {
    logic signed [AW-1:0] roll;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] yaw;
  } euler_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] quat_w_i = '0;
  logic signed [15:0] quat_x_i = '0;
  logic signed [15:0] quat_y_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [AW-1:0] roll_angle_o;
  logic signed [AW-1:0] pitch_angle_o;
  logic signed [AW-1:0] yaw_angle_o;

  euler_t angles_due[$];
  int unsigned send_idle_pct = 0;
  int unsigned take_idle_pct = 0;
  int unsigned mismatches = 0;

  quaternion_to_euler_top #(
    .ANGLE_WIDTH(AW),
    .CORDIC_STAGES(STAGES)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .quat_w_i(quat_w_i),
    .quat_x_i(quat_x_i),
    .quat_y_i(quat_y_i),
    .quat_z_i(quat_z_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .roll_angle_o(roll_angle_o),
    .pitch_angle_o(pitch_angle_o),
    .yaw_angle_o(yaw_angle_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // arithmetic shift right, rounding toward minus infinity
  function automatic longint sra(input longint v, input int unsigned s);
    return v >>> s;
  endfunction

  function automatic longint floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // micro-rotation angles, 2^31 = pi
  function automatic longint micro_angle(input int unsigned i);
    longint tab[32];
    tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
            41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20,
            10, 5, 2, 1, 0, 0};
    return (i < 32) ? tab[i] : 0;
  endfunction

  function automatic logic [AW-1:0] vector_angle(input longint yv, input longint xv);
    longint z;
    longint t;
    longint dx;
    longint dy;
    int unsigned sh;
    z = 0;
    sh = 32 - AW;
    if (xv == 0 && yv == 0) return '0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; z = 64'sd1 <<< 30;
      end else begin
        xv = -yv; yv = t; z = -(64'sd1 <<< 30);
      end
    end
    for (int unsigned i = 0; i < STAGES && i < 32; i++) begin
      dx = sra(yv, i);
      dy = sra(xv, i);
      if (yv < 0) begin
        xv -= dx; yv += dy; z -= micro_angle(i);
      end else begin
        xv += dx; yv -= dy; z += micro_angle(i);
      end
    end
    if (sh > 0) z = sra(z + (64'sd1 <<< (sh - 1)), sh);
    return z[AW-1:0];
  endfunction

  function automatic euler_t euler_of(input logic signed [15:0] qw, input logic signed [15:0] qx,
                                      input logic signed [15:0] qy, input logic signed [15:0] qz);
    longint w, x, y, z, one, ysq, r_num, r_den, p_t, y_num, y_den, p_c;
    euler_t e;
    w = qw; x = qx; y = qy; z = qz;
    one = 64'sd1 <<< 28;
    ysq = y * y;
    r_num = 2 * (w * x + y * z);
    r_den = one - 2 * (x * x + ysq);
    p_t = 2 * (w * y - z * x);
    y_num = 2 * (w * z + x * y);
    y_den = one - 2 * (ysq + z * z);
    if (p_t > one) p_t = one;
    if (p_t < -one) p_t = -one;
    p_c = floor_sqrt(longint'((64'sd1 <<< 56) - p_t * p_t));
    e.roll = vector_angle(r_num, r_den);
    e.pitch = vector_angle(p_t, p_c);
    e.yaw = vector_angle(y_num, y_den);
    return e;
  endfunction

  // hold valid and payload until the word is accepted
  task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] z);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    quat_w_i <= w;
    quat_x_i <= x;
    quat_y_i <= y;
    quat_z_i <= z;
    angles_due.push_back(euler_of(w, x, y, z));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // random receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= (take_idle_pct == 0) || ($urandom_range(99) >= take_idle_pct);
  end

  // compare each accepted word with the oldest expectation
  always @(posedge clk_i) begin
    euler_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (angles_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word roll=%0d pitch=%0d yaw=%0d", $time,
                 roll_angle_o, pitch_angle_o, yaw_angle_o);
      end else begin
        want = angles_due.pop_front();
        if (roll_angle_o !== want.roll) begin
          mismatches++;
          $display("%0t: roll expected %0d actual %0d", $time, want.roll, roll_angle_o);
        end
        if (pitch_angle_o !== want.pitch) begin
          mismatches++;
          $display("%0t: pitch expected %0d actual %0d", $time, want.pitch, pitch_angle_o);
        end
        if (yaw_angle_o !== want.yaw) begin
          mismatches++;
          $display("%0t: yaw expected %0d actual %0d", $time, want.yaw, yaw_angle_o);
        end
      end
    end
  end

  task automatic test_directed();
    logic [15:0] ext[6];
    ext = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000, 16'hffff};
    // zero quaternion, identity, gimbal lock both ways, pitch clamp
    send_quat(16'h0, 16'h0, 16'h0, 16'h0);
    send_quat(16'h4000, 16'h0, 16'h0, 16'h0);
    send_quat(16'h2d41, 16'h0, 16'h2d41, 16'h0);
    send_quat(16'h2d41, 16'h0, 16'hd2bf, 16'h0);
    send_quat(16'h7fff, 16'h0, 16'h7fff, 16'h0);
    send_quat(16'h7fff, 16'h0, 16'h8000, 16'h0);
    send_quat(16'h0, 16'h4000, 16'h0, 16'h0);
    send_quat(16'h0, 16'h0, 16'h0, 16'h4000);
    send_quat(16'h0, 16'h4000, 16'h0, 16'h4000);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    for (int i = 0; i < 12; i++)
      send_quat(ext[$urandom_range(5)], ext[$urandom_range(5)],
                ext[$urandom_range(5)], ext[$urandom_range(5)]);
  endtask

  task automatic test_random(input int unsigned n);
    logic [15:0] c[4];
    int unsigned scale;
    for (int unsigned k = 0; k < n; k++) begin
      scale = $urandom_range(3);
      for (int j = 0; j < 4; j++) begin
        c[j] = 16'($urandom);
        // mostly quarter-scale components, some full range
        if (scale != 0) c[j] = 16'($signed(c[j]) >>> 2);
      end
      send_quat(c[0], c[1], c[2], c[3]);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 28;
    take_idle_pct = 71;
    test_directed();
    test_random(RAND_WORDS / 3);
    send_idle_pct = 71;
    take_idle_pct = 28;
    test_random(RAND_WORDS / 3);
    send_idle_pct = 0;
    take_idle_pct = 0;
    test_random(RAND_WORDS / 3);
    drain();
    if (mismatches == 0 && angles_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
src/q2e_pkg.sv
src/q2e_sqrt_cell.sv
src/q2e_cordic_cell.sv
src/quaternion_to_euler_top.sv
test/testbench.sv
